FILE: rtl/nqbs_pkg.sv
package nqbs_pkg;

  localparam int unsigned MAX_QUEENS_DEF = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EMIT,
    ST_NOTFOUND
  } nqbs_state_e;

  typedef struct packed {
    logic start;
    logic step;
    logic emit;
    logic load_fail;
  } nqbs_cmd_t;

  typedef struct packed {
    logic bad_size;
    logic place_last;
    logic fail;
    logic emit_last;
    logic out_free;
  } nqbs_status_t;

endpackage

FILE: rtl/nqbs_ctrl.sv
module nqbs_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  nqbs_pkg::nqbs_status_t status_i,
  output nqbs_pkg::nqbs_cmd_t    cmd_o
);
  import nqbs_pkg::*;

  nqbs_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (status_i.bad_size || status_i.fail) begin
          state_d = ST_NOTFOUND;
        end else if (status_i.place_last) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free && status_i.emit_last) state_d = ST_IDLE;
      end
      ST_NOTFOUND: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.start = in_valid_i;
      end
      ST_SEARCH:   cmd_o.step      = !status_i.bad_size;
      ST_EMIT:     cmd_o.emit      = status_i.out_free;
      ST_NOTFOUND: cmd_o.load_fail = status_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

FILE: rtl/nqbs_datapath.sv
module nqbs_datapath #(
  parameter int unsigned MaxQueens = nqbs_pkg::MAX_QUEENS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [4:0]             board_size_i,
  input  nqbs_pkg::nqbs_cmd_t     cmd_i,
  output nqbs_pkg::nqbs_status_t  status_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   solution_found_o,
  output logic [3:0]             column_index_o,
  output logic [3:0]             queen_row_o,
  output logic                   last_result_o
);
  import nqbs_pkg::*;

  localparam int unsigned RW = (MaxQueens > 1) ? $clog2(MaxQueens) : 1;
  localparam int unsigned DL = 2 * MaxQueens - 1;
  localparam int unsigned DW = (DL > 1) ? $clog2(DL) : 1;

  logic [RW-1:0]        rpc_q [MaxQueens];
  logic [4:0]           n_q;
  logic [RW-1:0]        col_q;
  logic [RW:0]          r_q;
  logic [MaxQueens-1:0] rows_q;
  logic [DL-1:0]        dd_q;
  logic [DL-1:0]        du_q;

  logic                 out_valid_q;
  logic                 found_q;
  logic [3:0]           col_out_q;
  logic [3:0]           row_out_q;
  logic                 last_q;

  logic                 r_lt_n;
  logic [RW-1:0]        rlo;
  logic [RW-1:0]        rd_addr;
  logic [RW-1:0]        prev;
  logic [RW-1:0]        tr;
  logic [RW-1:0]        tc;
  logic [DW-1:0]        ddi;
  logic [DW-1:0]        dui;
  logic                 free;
  logic                 place;
  logic                 col_is_last;

  assign rlo     = r_q[RW-1:0];
  assign r_lt_n  = 6'(r_q) < 6'(n_q);
  assign rd_addr = cmd_i.emit ? col_q : col_q - RW'(1);
  assign prev    = rpc_q[rd_addr];

  // toggle target: candidate square when trying, previous queen when backing up
  assign tr  = r_lt_n ? rlo : prev;
  assign tc  = r_lt_n ? col_q : col_q - RW'(1);
  assign ddi = DW'(tr) + DW'(MaxQueens - 1) - DW'(tc);
  assign dui = DW'(tr) + DW'(tc);

  assign free        = !rows_q[tr] && !dd_q[ddi] && !du_q[dui];
  assign place       = r_lt_n && free;
  assign col_is_last = (6'(col_q) + 6'd1) == 6'(n_q);

  assign status_o.bad_size   = (n_q == 5'd0) || (6'(n_q) > 6'(MaxQueens));
  assign status_o.place_last = place && col_is_last;
  assign status_o.fail       = !r_lt_n && (col_q == '0);
  assign status_o.emit_last  = col_is_last;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.step && place) rpc_q[col_q] <= rlo;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q    <= '0;
      col_q  <= '0;
      r_q    <= '0;
      rows_q <= '0;
      dd_q   <= '0;
      du_q   <= '0;
    end else if (cmd_i.start) begin
      n_q    <= board_size_i;
      col_q  <= '0;
      r_q    <= '0;
      rows_q <= '0;
      dd_q   <= '0;
      du_q   <= '0;
    end else if (cmd_i.step) begin
      if (place) begin
        rows_q <= rows_q ^ (MaxQueens'(1) << tr);
        dd_q   <= dd_q ^ (DL'(1) << ddi);
        du_q   <= du_q ^ (DL'(1) << dui);
        col_q  <= col_is_last ? '0 : col_q + RW'(1);
        r_q    <= '0;
      end else if (r_lt_n) begin
        r_q <= r_q + (RW+1)'(1);
      end else if (col_q != '0) begin
        rows_q <= rows_q ^ (MaxQueens'(1) << tr);
        dd_q   <= dd_q ^ (DL'(1) << ddi);
        du_q   <= du_q ^ (DL'(1) << dui);
        col_q  <= tc;
        r_q    <= (RW+1)'(prev) + (RW+1)'(1);
      end
    end else if (cmd_i.emit) begin
      col_q <= col_q + RW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit || cmd_i.load_fail) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      found_q   <= 1'b1;
      col_out_q <= 4'(col_q);
      row_out_q <= 4'(prev);
      last_q    <= col_is_last;
    end else if (cmd_i.load_fail) begin
      found_q   <= 1'b0;
      col_out_q <= '0;
      row_out_q <= '0;
      last_q    <= 1'b1;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign solution_found_o = found_q;
  assign column_index_o   = col_out_q;
  assign queen_row_o      = row_out_q;
  assign last_result_o    = last_q;

endmodule

FILE: rtl/n_queens_backtrack_solver.sv
// N-queens solver: a request carrying board_size starts a depth-first search
// that fills columns left to right, trying rows in ascending order, and
// returns the first placement as one result per column (column_index,
// queen_row), last_result marking the final column. An unsolvable or
// out-of-range size (zero or above MAX_QUEENS) yields one result with
// solution_found low. The search tests one candidate square or backs up one
// column per clock, and the number of search steps depends on the board
// size; each result is loaded into the output register once that register
// is empty or its result is being taken. A new request is taken once the
// previous one has loaded its last result into the output register, even if
// that result is still waiting for transfer.
module n_queens_backtrack_solver #(
  parameter int unsigned MAX_QUEENS = nqbs_pkg::MAX_QUEENS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [4:0] board_size_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       solution_found_o,
  output logic [3:0] column_index_o,
  output logic [3:0] queen_row_o,
  output logic       last_result_o
);
  import nqbs_pkg::*;

  nqbs_cmd_t    cmd;
  nqbs_status_t status;

  nqbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  nqbs_datapath #(
    .MaxQueens (MAX_QUEENS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .board_size_i     (board_size_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .solution_found_o (solution_found_o),
    .column_index_o   (column_index_o),
    .queen_row_o      (queen_row_o),
    .last_result_o    (last_result_o)
  );

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !solution_found_o |->
      last_result_o && column_index_o == 4'd0 && queen_row_o == 4'd0)
    else $error("malformed not-found result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_result_o ##1 out_valid_o |->
      solution_found_o && column_index_o == 4'($past(column_index_o) + 4'd1))
    else $error("result columns out of sequence");
`endif

endmodule

FILE: dv/n_queens_result_checker.sv
module n_queens_result_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [4:0] board_size_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic       solution_found_i,
  input  logic [3:0] column_index_i,
  input  logic [3:0] queen_row_i,
  input  logic       last_result_i,
  output int         errors_o,
  output int         pending_o,
  output int         results_o,
  output int         unsolvable_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxQ = nqbs_pkg::MAX_QUEENS_DEF;

  typedef struct packed {
    logic       found;
    logic [3:0] col;
    logic [3:0] row;
    logic       last;
  } queen_result_t;

  queen_result_t placements_q[$];
  queen_result_t want;
  int err_count = 0;
  int result_count = 0;
  int unsolvable_count = 0;

  // Depth-first search, columns left to right, rows ascending.
  function automatic void place_queens(input int unsigned n);
    logic [3:0]        rows [MaxQ];
    logic [MaxQ-1:0]   row_busy;
    logic [2*MaxQ-2:0] down_busy;
    logic [2*MaxQ-2:0] up_busy;
    int unsigned col;
    int unsigned r;
    int unsigned start;
    int unsigned prev;
    bit placed;
    bit solved;
    bit done;
    queen_result_t res;
    row_busy = '0;
    down_busy = '0;
    up_busy = '0;
    solved = 1'b0;
    if (n >= 1 && n <= MaxQ) begin
      col = 0;
      start = 0;
      done = 1'b0;
      while (!done) begin
        placed = 1'b0;
        r = start;
        while (r < n && !placed) begin
          if (!row_busy[r] && !down_busy[r + MaxQ - 1 - col] && !up_busy[r + col]) begin
            rows[col] = r[3:0];
            row_busy[r] = 1'b1;
            down_busy[r + MaxQ - 1 - col] = 1'b1;
            up_busy[r + col] = 1'b1;
            placed = 1'b1;
          end else begin
            r++;
          end
        end
        if (placed) begin
          col++;
          start = 0;
          if (col >= n) begin
            solved = 1'b1;
            done = 1'b1;
          end
        end else if (col == 0) begin
          done = 1'b1;
        end else begin
          col--;
          prev = rows[col];
          row_busy[prev] = 1'b0;
          down_busy[prev + MaxQ - 1 - col] = 1'b0;
          up_busy[prev + col] = 1'b0;
          start = prev + 1;
        end
      end
    end
    if (!solved) begin
      res = '{found: 1'b0, col: 4'd0, row: 4'd0, last: 1'b1};
      placements_q.push_back(res);
      unsolvable_count++;
    end else begin
      for (int unsigned k = 0; k < n; k++) begin
        res.found = 1'b1;
        res.col = k[3:0];
        res.row = rows[k];
        res.last = (k + 1 == n);
        placements_q.push_back(res);
      end
    end
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      errors_o <= 0;
      pending_o <= 0;
      results_o <= 0;
      unsolvable_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (placements_q.size() == 0) begin
          $error("result transfer with nothing expected: found=%0d col=%0d row=%0d last=%0d",
                 solution_found_i, column_index_i, queen_row_i, last_result_i);
          err_count++;
        end else begin
          want = placements_q.pop_front();
          result_count++;
          if (solution_found_i !== want.found) begin
            $error("solution_found: expected %0d, actual %0d", want.found, solution_found_i);
            err_count++;
          end
          if (column_index_i !== want.col) begin
            $error("column_index: expected %0d, actual %0d", want.col, column_index_i);
            err_count++;
          end
          if (queen_row_i !== want.row) begin
            $error("queen_row: expected %0d, actual %0d", want.row, queen_row_i);
            err_count++;
          end
          if (last_result_i !== want.last) begin
            $error("last_result: expected %0d, actual %0d", want.last, last_result_i);
            err_count++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        place_queens(board_size_i);
      end
      errors_o <= err_count;
      pending_o <= placements_q.size();
      results_o <= result_count;
      unsolvable_o <= unsolvable_count;
    end
  end

endmodule

FILE: dv/tb_n_queens_backtrack_solver.sv
module tb_n_queens_backtrack_solver;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 4_000_000;
  localparam int unsigned NumRandom = 77;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [4:0] board_size = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       solution_found;
  logic [3:0] column_index;
  logic [3:0] queen_row;
  logic       last_result;
  logic       no_idle = 1'b0;

  int errors;
  int pending;
  int results;
  int unsolvable;
  int unsigned cycles = 0;
  int unsigned sent = 0;
  int unsigned directed = 0;

  n_queens_backtrack_solver u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .board_size_i    (board_size),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .solution_found_o(solution_found),
    .column_index_o  (column_index),
    .queen_row_o     (queen_row),
    .last_result_o   (last_result)
  );

  n_queens_result_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .board_size_i    (board_size),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .solution_found_i(solution_found),
    .column_index_i  (column_index),
    .queen_row_i     (queen_row),
    .last_result_i   (last_result),
    .errors_o        (errors),
    .pending_o       (pending),
    .results_o       (results),
    .unsolvable_o    (unsolvable)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready <= no_idle || ($urandom_range(99) >= 37);
  end

  task automatic send_request(input logic [4:0] size);
    if (!no_idle && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < 37) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    board_size <= size;
    do @(posedge clk_i); while (!in_ready);
    sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [4:0] pick_size();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 55) return 5'($urandom_range(9, 1));
    if (p < 62) return 5'd0;
    if (p < 72) return 5'($urandom_range(31, 17));
    if (p < 92) return 5'($urandom_range(13, 10));
    return 5'($urandom_range(15, 14));
  endfunction

  initial begin
    logic [4:0] directed_sizes [$];
    directed_sizes = '{5'd1, 5'd2, 5'd3, 5'd0, 5'd17, 5'd31, 5'd4, 5'd5, 5'd6, 5'd7,
                       5'd8, 5'd4, 5'd16, 5'd15, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13,
                       5'd14, 5'd1, 5'd3, 5'd24};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_sizes[i]) send_request(directed_sizes[i]);
    directed = sent;

    for (int unsigned i = 0; i < NumRandom; i++) begin
      no_idle <= (i >= 40 && i < 60);
      if (i == 70) wait_drained();
      send_request(pick_size());
    end
    no_idle <= 1'b0;

    wait_drained();
    repeat (50) @(posedge clk_i);

    if (pending != 0) begin
      $error("%0d expected results never arrived", pending);
    end
    $display("Sent %0d solve requests (%0d directed) with sizes 0..31, random stalls on both sides.",
             sent, directed);
    $display("Checked %0d result transfers, %0d requests without a placement.",
             results, unsolvable);
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/nqbs_pkg.sv
rtl/nqbs_ctrl.sv
rtl/nqbs_datapath.sv
rtl/n_queens_backtrack_solver.sv
dv/n_queens_result_checker.sv
dv/tb_n_queens_backtrack_solver.sv
